### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/vtpd_pkg.sv
// Shared constants and types for the vertex transform block.
`timescale 1ns / 1ps
package vtpd_pkg;
    localparam int COORD_W       = 32;
    localparam int CFG_W         = 64;
    localparam int NUM_REGS      = 8;
    localparam int REG_AW        = $clog2(NUM_REGS);
    localparam int CFG_IDX_W     = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ZERO_BAND_DEF = 1;
    localparam int QUEUE_DEPTH   = 8;
    localparam int DIV_STEPS     = 2;
    localparam int DIV_STAGES    = COORD_W / DIV_STEPS;
    // exact sum of three 32x32 products plus headroom
    localparam int SUM_W         = 2 * COORD_W + 3;
    localparam int LANES         = 3;

    typedef logic [CFG_W-1:0] cfg_word_t;

    // identity matrix
    localparam cfg_word_t REG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic             divide;
        logic [LANES-1:0] neg;
    } vtpd_ctrl_t;
endpackage

### rtl/core/vtpd_queue.sv
// Small FIFO between the front and back halves.
`timescale 1ns / 1ps
module vtpd_queue import vtpd_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] q_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_pop;

    assign q_valid = count_reg != '0;
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### rtl/core/vtpd_front.sv
// Front half: input transfer, matrix products, column sums and divide classification.
`timescale 1ns / 1ps
module vtpd_front import vtpd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ZERO_BAND = ZERO_BAND_DEF,
    parameter int CW        = SUM_W - FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_W-1:0]      in_x,
    input  logic signed [COORD_W-1:0]      in_y,
    input  logic signed [COORD_W-1:0]      in_z,
    input  cfg_word_t                      mat [NUM_REGS],
    input  logic                           pop,
    output logic                           push,
    output vtpd_ctrl_t                     push_ctrl,
    output logic [LANES-1:0][CW-1:0]       push_mag,
    output logic [CW-1:0]                  push_ud
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic signed [CW-1:0] ZB_POS = CW'(ZERO_BAND);
    localparam logic signed [CW-1:0] ZB_NEG = -ZB_POS;

    logic signed [COORD_W-1:0]   m [4][4];
    logic signed [COORD_W-1:0]   pin [LANES];
    logic signed [2*COORD_W-1:0] prod_reg [LANES][4];
    logic signed [SUM_W-1:0]     sum_reg [4];
    logic signed [CW-1:0]        col_reg [4];
    logic [LANES-1:0][CW-1:0]    mag_reg;
    logic [CW-1:0]               ud_reg;
    vtpd_ctrl_t                  ctrl_reg;
    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        acc;
    logic signed [CW-1:0]        w;
    logic                        div;

    assign pin[0] = in_x;
    assign pin[1] = in_y;
    assign pin[2] = in_z;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m[r][c] = mat[2*r + c/2][(c%2)*COORD_W +: COORD_W];
            end
        end
    end

    // Credits cover every item between the input port and the queue read.
    assign in_stall = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign acc      = in_valid && !in_stall;
    assign cnt_next = cnt_reg + CNT_W'(acc) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            v1_reg  <= acc;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
        end
    end

    assign w   = col_reg[3];
    assign div = (w > ZB_POS) || (w < ZB_NEG);

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[i][c] <= pin[i] * m[i][c];
                end
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            sum_reg[c] <= SUM_W'(prod_reg[0][c]) + SUM_W'(prod_reg[1][c])
                        + SUM_W'(prod_reg[2][c]);
            // floor to the fraction point, then add the translation row
            col_reg[c] <= CW'(sum_reg[c] >>> FRAC_BITS) + CW'(m[3][c]);
        end
        for (int i = 0; i < LANES; i++)
        begin
            mag_reg[i]      <= col_reg[i][CW-1] ? CW'(-col_reg[i]) : CW'(col_reg[i]);
            ctrl_reg.neg[i] <= div ? (col_reg[i][CW-1] ^ w[CW-1]) : col_reg[i][CW-1];
        end
        ud_reg          <= w[CW-1] ? CW'(-w) : CW'(w);
        ctrl_reg.divide <= div;
    end

    assign push      = v4_reg;
    assign push_ctrl = ctrl_reg;
    assign push_mag  = mag_reg;
    assign push_ud   = ud_reg;
endmodule

### rtl/core/vtpd_back.sv
// Back half: pipelined restoring divide per lane, clamp and output register.
`timescale 1ns / 1ps
module vtpd_back import vtpd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CW        = SUM_W - FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  vtpd_ctrl_t                q_ctrl,
    input  logic [LANES-1:0][CW-1:0]  q_mag,
    input  logic [CW-1:0]             q_ud,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic                      divided,
    output logic                      saturated
);
    localparam int NS = DIV_STAGES + 1;
    localparam logic [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    logic                     vld_reg [NS];
    logic                     div_reg [NS];
    logic [LANES-1:0]         neg_reg [NS];
    logic [LANES-1:0]         big_reg [NS];
    logic [CW-1:0]            rem_reg [NS][LANES];
    logic [COORD_W-1:0]       dq_reg  [NS][LANES];
    logic [CW-1:0]            ud_reg  [NS];

    logic [CW-1:0]            rem_next [DIV_STAGES][LANES];
    logic [COORD_W-1:0]       dq_next  [DIV_STAGES][LANES];

    logic                     out_valid_reg;
    logic [COORD_W-1:0]       res_reg [LANES];
    logic                     divided_reg, saturated_reg;
    logic [COORD_W-1:0]       res_next [LANES];
    logic [LANES-1:0]         sat_lane;
    logic                     en;

    // whole back pipe holds while a finished result waits
    assign en  = !(out_valid_reg && out_stall);
    assign pop = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= q_valid;
            for (int s = 1; s < NS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_valid_reg <= vld_reg[NS-1];
        end
    end

    // Stage 0: overflow precheck and divider setup. Quotient is 32 bits
    // unless (mag << FRAC_BITS) >= ud << 32.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= q_ctrl.divide;
            neg_reg[0] <= q_ctrl.neg;
            ud_reg[0]  <= q_ud;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= q_mag[l] >> (COORD_W - FRAC_BITS);
                if (q_ctrl.divide)
                begin
                    big_reg[0][l] <= (q_mag[l] >> (COORD_W - FRAC_BITS)) >= q_ud;
                    dq_reg[0][l]  <= q_mag[l][COORD_W-1:0] << FRAC_BITS;
                end
                else
                begin
                    big_reg[0][l] <= |q_mag[l][CW-1:COORD_W];
                    dq_reg[0][l]  <= q_mag[l][COORD_W-1:0];
                end
            end
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        always_comb
        begin
            logic [CW:0]         t;
            logic [CW-1:0]       r;
            logic [COORD_W-1:0]  d;
            logic                ge;
            for (int l = 0; l < LANES; l++)
            begin
                r = rem_reg[s][l];
                d = dq_reg[s][l];
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    t  = {r, d[COORD_W-1]};
                    ge = t >= {1'b0, ud_reg[s]};
                    r  = ge ? CW'(t - {1'b0, ud_reg[s]}) : CW'(t);
                    d  = {d[COORD_W-2:0], ge};
                end
                // pass-through items keep their magnitude in dq
                rem_next[s][l] = div_reg[s] ? r : rem_reg[s][l];
                dq_next[s][l]  = div_reg[s] ? d : dq_reg[s][l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[s+1] <= div_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                big_reg[s+1] <= big_reg[s];
                ud_reg[s+1]  <= ud_reg[s];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s+1][l] <= rem_next[s][l];
                    dq_reg[s+1][l]  <= dq_next[s][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (neg_reg[NS-1][l])
            begin
                sat_lane[l] = big_reg[NS-1][l] || (dq_reg[NS-1][l] > Q_MIN);
                res_next[l] = sat_lane[l] ? Q_MIN : -dq_reg[NS-1][l];
            end
            else
            begin
                sat_lane[l] = big_reg[NS-1][l] || dq_reg[NS-1][l][COORD_W-1];
                res_next[l] = sat_lane[l] ? Q_MAX : dq_reg[NS-1][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                res_reg[l] <= res_next[l];
            end
            divided_reg   <= div_reg[NS-1];
            saturated_reg <= |sat_lane;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign divided   = divided_reg;
    assign saturated = saturated_reg;
endmodule

### rtl/core/vertex_transform_perspective_divide.sv
// Top level: matrix registers, front half, queue and back half.
`timescale 1ns / 1ps
// Transforms one Q16.16 point (x, y, z, 1) per cycle by the 4x4 row-vector
// matrix in the eight 64-bit registers (identity after reset), then divides
// x, y and z by w when |w| exceeds ZERO_BAND, clamping to the signed 32-bit
// range. Throughput is one point per clock while in_stall is low. Between
// input transfer and result transfer a point passes four front stages
// (products, sums, column floor, magnitude and sign), one queue write, a
// divider setup stage, a 16-stage restoring divider that retires two
// quotient bits per stage in each of three lanes, and the output register.
// An 8-entry queue lets the input side keep taking points while a result
// waits on out_stall. Write the registers only while no point is in flight.
module vertex_transform_perspective_divide import vtpd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ZERO_BAND = ZERO_BAND_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [COORD_W-1:0] in_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic                      divided,
    output logic                      saturated
);
    localparam int CW = SUM_W - FRAC_BITS;
    localparam int EW = $bits(vtpd_ctrl_t) + (LANES + 1) * CW;

    cfg_word_t                mat_reg [NUM_REGS];
    logic                     push, pop, q_valid;
    vtpd_ctrl_t               push_ctrl, q_ctrl;
    logic [LANES-1:0][CW-1:0] push_mag, q_mag;
    logic [CW-1:0]            push_ud, q_ud;
    logic [EW-1:0]            q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mat_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            mat_reg[cfg_index[REG_AW-1:0]] <= cfg_wdata;
        end
    end

    vtpd_front #(
        .FRAC_BITS (FRAC_BITS),
        .ZERO_BAND (ZERO_BAND),
        .CW        (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .mat       (mat_reg),
        .pop       (pop),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_mag  (push_mag),
        .push_ud   (push_ud)
    );

    vtpd_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctrl, push_mag, push_ud}),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    assign {q_ctrl, q_mag, q_ud} = q_data;

    vtpd_back #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ctrl    (q_ctrl),
        .q_mag     (q_mag),
        .q_ud      (q_ud),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .divided   (divided),
        .saturated (saturated)
    );
endmodule

### rtl/core/vtpd_checker.sv
// Port-level checker for the vertex transform block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vtpd_port_checks import vtpd_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic [CFG_IDX_W-1:0]      cfg_index,
    input logic [CFG_W-1:0]          cfg_wdata,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic signed [COORD_W-1:0] in_x,
    input logic signed [COORD_W-1:0] in_y,
    input logic signed [COORD_W-1:0] in_z,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [COORD_W-1:0] out_x,
    input logic signed [COORD_W-1:0] out_y,
    input logic signed [COORD_W-1:0] out_z,
    input logic                      divided,
    input logic                      saturated
);
    localparam logic signed [COORD_W-1:0] S_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] S_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    logic [7:0] pend_reg, pend_next;
    logic       in_xfer, out_xfer;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign pend_next = pend_reg + 8'(in_xfer) - 8'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `VTPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_x) && $stable(divided) && $stable(saturated))
    `VTPD_ASSERT_IMPLY(a_no_orphan, clk, rst_n, out_valid, pend_reg != 8'd0)
    `VTPD_ASSERT_IMPLY(a_sat_clamped, clk, rst_n, out_valid && saturated, out_x == S_MIN || out_x == S_MAX || out_y == S_MIN || out_y == S_MAX || out_z == S_MIN || out_z == S_MAX)
endmodule

bind vertex_transform_perspective_divide vtpd_port_checks u_vtpd_checker (.*);
